/* rtl/tvp_pkg.sv */
package tvp_pkg;

  localparam int VW  = 32;
  localparam int DTW = 16;
  localparam int DTF = 16;

  typedef logic signed [VW-1:0] val_t;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_ACCEL  = 3'd1;
  localparam logic [2:0] PH_CRUISE = 3'd2;
  localparam logic [2:0] PH_DECEL  = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_ABORT = 2'd2;
  localparam logic [1:0] CMD_RESET = 2'd3;

  localparam logic [1:0] REG_ACCEL = 2'd0;
  localparam logic [1:0] REG_SMIN  = 2'd1;
  localparam logic [1:0] REG_SMAX  = 2'd2;
  localparam logic [1:0] REG_THR   = 2'd3;

  localparam logic [1:0] MUL_ACC_DT = 2'd0;
  localparam logic [1:0] MUL_VSQ    = 2'd1;
  localparam logic [1:0] MUL_DIST   = 2'd2;
  localparam logic [1:0] MUL_V_DT   = 2'd3;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       vupd;
    logic       vsq_save;
    logic       cmp;
    logic       pupd;
    logic       out_load;
  } tvp_cmd_t;

  typedef struct packed {
    logic tick_go;
    logic vfin;
    logic out_busy;
  } tvp_stat_t;

endpackage

/* rtl/tvp_in_if.sv */
interface tvp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] tick_dt;
  logic signed [31:0] move_target;
  logic signed [31:0] move_speed;

  modport source (output valid, command, tick_dt, move_target, move_speed, input ready);
  modport sink   (input valid, command, tick_dt, move_target, move_speed, output ready);
endinterface

/* rtl/tvp_out_if.sv */
interface tvp_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] speed_out;
  logic signed [31:0] position_out;
  logic [2:0]  phase_code;
  logic        done_flag;

  modport source (output valid, speed_out, position_out, phase_code, done_flag, input ready);
  modport sink   (input valid, speed_out, position_out, phase_code, done_flag, output ready);
endinterface

/* rtl/tvp_cfg_if.sv */
interface tvp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/tvp_datapath.sv */
module tvp_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  tvp_pkg::tvp_cmd_t  cmd,
  output tvp_pkg::tvp_stat_t stat,
  input  logic [1:0]         in_command,
  input  logic [15:0]        in_tick_dt,
  input  logic signed [31:0] in_move_target,
  input  logic signed [31:0] in_move_speed,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_speed,
  output logic signed [31:0] out_position,
  output logic [2:0]         out_phase,
  output logic               out_done
);
  import tvp_pkg::*;

  function automatic val_t sat34(input logic signed [VW+1:0] x);
    if (x > $signed({{2{1'b0}}, VMAX})) begin
      return VMAX;
    end else if (x < $signed({{2{1'b1}}, VMIN})) begin
      return VMIN;
    end else begin
      return x[VW-1:0];
    end
  endfunction

  logic [VW-2:0]    accel_r, thr_r;
  val_t             smin_r, smax_r;
  val_t             goal_r, cruise_r, pos_r, vel_r;
  logic [2:0]       phase_r;
  logic [DTW-1:0]   dt_r;
  logic [VW:0]      rem_r;
  logic             zrep_r;
  logic [2*VW-1:0]  vsq_r;
  logic [2*VW:0]    prod_r;
  logic             out_valid_r;
  val_t             out_speed_r, out_pos_r;
  logic [2:0]       out_phase_r;

  logic [VW-2:0]    eff_accel;
  logic [VW-1:0]    vmag;
  logic [VW:0]      mul_a;
  logic [VW-1:0]    mul_b;
  logic             fwd;
  logic signed [VW+1:0] vel_x, delta_x, dstep_x;
  val_t             vel_up, vel_dn, vel_dec;
  logic             stopped;

  assign eff_accel = (accel_r == '0) ? {{(VW-2){1'b0}}, 1'b1} : accel_r;
  assign vmag      = vel_r[VW-1] ? (~vel_r + 1'b1) : vel_r;
  assign fwd       = ~goal_r[VW-1];
  assign vel_x     = {{2{vel_r[VW-1]}}, vel_r};
  assign delta_x   = {3'b000, prod_r[DTF+VW-2:DTF]};
  assign vel_up    = sat34(vel_x + delta_x);
  assign vel_dn    = sat34(vel_x - delta_x);
  assign vel_dec   = fwd ? vel_dn : vel_up;
  assign stopped   = fwd ? (vel_dec <= 0) : (vel_dec >= 0);
  assign dstep_x   = vel_r[VW-1] ? -$signed({2'b00, prod_r[DTF+VW-1:DTF]})
                                 :  $signed({2'b00, prod_r[DTF+VW-1:DTF]});

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_ACC_DT: begin
        mul_a = {2'b00, eff_accel};
        mul_b = {{(VW-DTW){1'b0}}, dt_r};
      end
      MUL_VSQ: begin
        mul_a = {1'b0, vmag};
        mul_b = vmag;
      end
      MUL_DIST: begin
        mul_a = rem_r;
        mul_b = {eff_accel, 1'b0};
      end
      default: begin
        mul_a = {1'b0, vmag};
        mul_b = {{(VW-DTW){1'b0}}, dt_r};
      end
    endcase
  end

  assign stat.tick_go  = (in_command == CMD_TICK) && (in_tick_dt != '0) &&
                         (phase_r == PH_ACCEL || phase_r == PH_CRUISE ||
                          phase_r == PH_DECEL);
  assign stat.vfin     = (phase_r == PH_DECEL) &&
                         ((rem_r <= {2'b00, thr_r}) || stopped);
  assign stat.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.vsq_save) begin
      vsq_r <= prod_r[2*VW-1:0];
    end
    if (cmd.out_load) begin
      out_speed_r <= zrep_r ? '0 : vel_r;
      out_pos_r   <= pos_r;
      out_phase_r <= phase_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [VW:0]      spd_mag, tgt_mag;
    val_t             m;
    logic signed [VW:0] diff;
    val_t             npos;
    if (!rst_n) begin
      accel_r     <= 31'd256;
      smin_r      <= VMIN;
      smax_r      <= VMAX;
      thr_r       <= 31'd1280;
      goal_r      <= '0;
      cruise_r    <= '0;
      pos_r       <= '0;
      vel_r       <= '0;
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ACCEL: accel_r <= cfg_data[VW-2:0];
          REG_SMIN:  smin_r  <= cfg_data;
          REG_SMAX:  smax_r  <= cfg_data;
          default:   thr_r   <= cfg_data[VW-2:0];
        endcase
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.load) begin
        zrep_r <= (in_command == CMD_TICK) && (in_tick_dt == '0);
        dt_r   <= in_tick_dt;
        diff   = {goal_r[VW-1], goal_r} - {pos_r[VW-1], pos_r};
        rem_r  <= diff[VW] ? (~diff + 1'b1) : diff;
        unique case (in_command)
          CMD_START: begin
            if (in_move_speed == '0) begin
              phase_r <= PH_IDLE;
              pos_r   <= '0;
              vel_r   <= '0;
            end else begin
              spd_mag = in_move_speed[VW-1] ? (~{1'b1, in_move_speed} + 1'b1)
                                            : {1'b0, in_move_speed};
              m = (spd_mag > {1'b0, VMAX}) ? VMAX : spd_mag[VW-1:0];
              if (in_move_target[VW-1]) begin
                m = -m;
              end
              if (m < smin_r) begin
                m = smin_r;
              end else if (m > smax_r) begin
                m = smax_r;
              end
              tgt_mag = in_move_target[VW-1] ? (~{1'b1, in_move_target} + 1'b1)
                                             : {1'b0, in_move_target};
              goal_r   <= in_move_target;
              cruise_r <= m;
              vel_r    <= '0;
              if (tgt_mag <= {2'b00, thr_r}) begin
                pos_r   <= in_move_target;
                phase_r <= PH_DONE;
              end else begin
                pos_r   <= '0;
                phase_r <= PH_ACCEL;
              end
            end
          end
          CMD_ABORT: begin
            vel_r   <= '0;
            phase_r <= PH_DONE;
          end
          CMD_RESET: begin
            goal_r   <= '0;
            cruise_r <= '0;
            pos_r    <= '0;
            vel_r    <= '0;
            phase_r  <= PH_IDLE;
          end
          default: begin
            if (in_tick_dt != '0 && (phase_r == PH_IDLE || phase_r == PH_DONE)) begin
              vel_r <= '0;
            end
          end
        endcase
      end

      if (cmd.vupd) begin
        case (phase_r)
          PH_ACCEL: begin
            if (fwd ? (vel_up >= cruise_r) : (vel_dn <= cruise_r)) begin
              vel_r   <= cruise_r;
              phase_r <= PH_CRUISE;
            end else begin
              vel_r <= fwd ? vel_up : vel_dn;
            end
          end
          PH_CRUISE: vel_r <= cruise_r;
          default: begin
            if (stat.vfin) begin
              pos_r   <= goal_r;
              vel_r   <= '0;
              phase_r <= PH_DONE;
            end else begin
              vel_r <= vel_dec;
            end
          end
        endcase
      end

      if (cmd.cmp && phase_r != PH_DECEL && prod_r <= {1'b0, vsq_r}) begin
        phase_r <= PH_DECEL;
      end

      if (cmd.pupd) begin
        npos = sat34({{2{pos_r[VW-1]}}, pos_r} + dstep_x);
        if (fwd ? (npos > goal_r) : (npos < goal_r)) begin
          pos_r   <= goal_r;
          vel_r   <= '0;
          phase_r <= PH_DONE;
        end else begin
          pos_r <= npos;
        end
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_speed    = out_speed_r;
  assign out_position = out_pos_r;
  assign out_phase    = out_phase_r;
  assign out_done     = (out_phase_r == PH_DONE);

endmodule

/* rtl/tvp_ctrl.sv */
module tvp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tvp_pkg::tvp_stat_t stat,
  output tvp_pkg::tvp_cmd_t  cmd
);
  import tvp_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MD   = 4'd1;
  localparam logic [3:0] ST_VUPD = 4'd2;
  localparam logic [3:0] ST_MV   = 4'd3;
  localparam logic [3:0] ST_MR   = 4'd4;
  localparam logic [3:0] ST_CMP  = 4'd5;
  localparam logic [3:0] ST_MP   = 4'd6;
  localparam logic [3:0] ST_PUPD = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0] st_r, st_nxt;

  assign in_ready = (st_r == ST_IDLE);

  always_comb begin
    cmd    = '0;
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          st_nxt   = stat.tick_go ? ST_MD : ST_FIN;
        end
      end
      ST_MD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ACC_DT;
        st_nxt      = ST_VUPD;
      end
      ST_VUPD: begin
        cmd.vupd = 1'b1;
        st_nxt   = stat.vfin ? ST_FIN : ST_MV;
      end
      ST_MV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VSQ;
        st_nxt      = ST_MR;
      end
      ST_MR: begin
        cmd.vsq_save = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_DIST;
        st_nxt       = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp = 1'b1;
        st_nxt  = ST_MP;
      end
      ST_MP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_V_DT;
        st_nxt      = ST_PUPD;
      end
      ST_PUPD: begin
        cmd.pupd = 1'b1;
        st_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          st_nxt       = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

`ifndef SYNTH
  a_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.vupd, cmd.cmp, cmd.pupd, cmd.out_load}))
    else $error("datapath strobes overlap");
  a_md_seq: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_MD |=> st_r == ST_VUPD)
    else $error("multiply step not followed by velocity update");
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FIN && !stat.out_busy) |=> st_r == ST_IDLE)
    else $error("result not released when output slot free");
`endif

endmodule

/* rtl/trapezoid_velocity_planner_top.sv */
// Trapezoidal move planner. Each beat on in_ch carries a command (tick, start,
// abort or reset) with its tick time, relative target and cruise speed, and
// produces exactly one beat on out_ch with speed, position, phase and done.
// Configuration registers are written over cfg_ch, which is always ready;
// writes are expected only while no beat is in flight.
// Start, abort, reset, a zero-length tick and a tick while idle or done go
// straight to the final step. A tick in an active phase is paced by
// one shared 33x32 multiplier used four times in sequence (acceleration step,
// speed squared, braking distance, position step); a tick that ends the move
// in deceleration stops after the acceleration step. The result is
// registered in the final step once the output register is free; a new beat
// is taken only after the previous one has been through the final step.
// in_ch is ready whenever the controller is idle, so the next beat can be
// taken while a result still waits on out_ch. If out_ch stalls, the finished
// item waits in the final step and no further beat is taken until the output
// register is free.
// After rst_n the planner is idle at zero and the registers hold their
// defaults.
module trapezoid_velocity_planner_top (
  input logic      clk,
  input logic      rst_n,
  tvp_in_if.sink   in_ch,
  tvp_out_if.source out_ch,
  tvp_cfg_if.sink  cfg_ch
);
  import tvp_pkg::*;

  tvp_cmd_t  cmd;
  tvp_stat_t stat;
  logic      in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  tvp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tvp_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_command     (in_ch.command),
    .in_tick_dt     (in_ch.tick_dt),
    .in_move_target (in_ch.move_target),
    .in_move_speed  (in_ch.move_speed),
    .cfg_valid      (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_speed      (out_ch.speed_out),
    .out_position   (out_ch.position_out),
    .out_phase      (out_ch.phase_code),
    .out_done       (out_ch.done_flag)
  );

endmodule
